[src/hctg_pkg.sv]
// Hop channel table generator: shared types, constants and the channel fold.
// No dependencies; used by hop_channel_table_generator_unit.
`timescale 1ns / 1ps
`default_nettype none

package hctg_pkg;

  // List geometry: HOP_COUNT hop slots plus one bind slot.
  localparam logic [5:0] HOP_COUNT = 6'd47;
  localparam int unsigned LIST_DEPTH = 48;

  // Generator constants; only the low 16 bits reach a 16-bit state.
  localparam logic [31:0] LCG_MUL    = 32'h0019_660D;
  localparam logic [31:0] LCG_ADD    = 32'h3C6E_F35F;
  localparam logic [15:0] LCG_MUL_LO = LCG_MUL[15:0];
  localparam logic [15:0] LCG_ADD_LO = LCG_ADD[15:0];

  localparam logic [7:0] CHAN_MOD    = 8'h4B;
  localparam logic [6:0] BAND2_START = 7'd27;
  localparam logic [6:0] BAND3_START = 7'd53;
  localparam logic [4:0] BAND1_CAP   = 5'd16;
  localparam logic [4:0] BAND2_CAP   = 5'd15;
  localparam logic [4:0] BAND3_CAP   = 5'd16;
  localparam logic [6:0] MIN_SPACING = 7'd5;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_STEP,
    ST_SCREEN,
    ST_CHECK,
    ST_SCAN,
    ST_OUT_RD,
    ST_OUT_SHOW
  } state_t;

  // High byte mod 75, plus one: channel 1..75.
  function automatic logic [6:0] chan_of(input logic [7:0] hi);
    logic [7:0] r;
    if (hi >= 8'(3 * CHAN_MOD))      r = hi - 8'(3 * CHAN_MOD);
    else if (hi >= 8'(2 * CHAN_MOD)) r = hi - 8'(2 * CHAN_MOD);
    else if (hi >= CHAN_MOD)         r = hi - CHAN_MOD;
    else                             r = hi;
    return r[6:0] + 7'd1;
  endfunction

endpackage

`default_nettype wire

[src/hop_channel_table_generator_unit.sv]
// Hop channel table generator, top level: sequencer, list memory, output stage.
// Depends on hctg_pkg.
`timescale 1ns / 1ps
`default_nettype none

// Channel | Ports                          | Item
// --------+--------------------------------+-------------------------------------
// input   | in_tvalid/in_tready/in_tdata   | transmitter_id
// output  | out_tvalid/out_tready/out_tdata| slot, channel (+ out_tlast = last)
//
// One id in, 48 items out (slots 0..47, bind slot last with tlast).
// Each candidate passes an LCG step, a fold and a screen; once the list is non-empty
// a candidate that passes the screen adds a duplicate scan through the list memory
// (cut short when a duplicate turns up early). A run also ends after 65536 rejected
// candidates in a row when the generator is stuck; each output item is then read from
// the list memory and shown.
// Not ready for a new id from acceptance until the tlast item is taken.
// Output stalls simply hold the current item. Reset: rst_n synchronous, low.
module hop_channel_table_generator_unit (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [15:0] in_tdata,   // [15:0] transmitter_id
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [15:0]      out_tdata,  // [5:0] slot, [12:6] channel, [15:13] zero
  output logic             out_tlast   // last
);

  hctg_pkg::state_t state_r, state_nxt;

  logic [15:0] lcg_r, lcg_nxt;
  logic [6:0]  cand_r, cand_nxt;
  logic [6:0]  prev_r, prev_nxt;
  logic [5:0]  fill_r, fill_nxt;
  logic [4:0]  n1_r, n1_nxt, n2_r, n2_nxt, n3_r, n3_nxt;
  logic [15:0] miss_r, miss_nxt;
  logic [5:0]  idx_r, idx_nxt;
  logic        pend_r, pend_nxt;
  logic [5:0]  slot_r, slot_nxt;

  // List memory: only slots below fill_r are ever written/trusted.
  logic [6:0]  mem [hctg_pkg::LIST_DEPTH];
  logic [6:0]  rd_r;
  logic [5:0]  mem_addr;
  logic        wr_en;

  logic [15:0] prod;
  logic [6:0]  chan_gap;
  logic        band_full, spacing_bad, issue, take, drop;

  // Multiplier for the generator step (low 16 bits kept).
  assign prod = lcg_r * hctg_pkg::LCG_MUL_LO;

  assign chan_gap = (cand_r > prev_r) ? cand_r - prev_r : prev_r - cand_r;
  assign spacing_bad = (fill_r != '0) && (chan_gap < hctg_pkg::MIN_SPACING);

  always_comb begin
    if (cand_r < hctg_pkg::BAND2_START)      band_full = (n1_r >= hctg_pkg::BAND1_CAP);
    else if (cand_r < hctg_pkg::BAND3_START) band_full = (n2_r >= hctg_pkg::BAND2_CAP);
    else                                     band_full = (n3_r >= hctg_pkg::BAND3_CAP);
  end

  assign issue    = (idx_r < fill_r);
  // Output states keep reading the current slot so a stalled item holds still.
  assign mem_addr = ((state_r == hctg_pkg::ST_OUT_RD) ||
                     (state_r == hctg_pkg::ST_OUT_SHOW)) ? slot_r : idx_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[fill_r] <= cand_r;
    end
    rd_r <= mem[mem_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= hctg_pkg::ST_IDLE;
      lcg_r   <= '0;
      fill_r  <= '0;
      n1_r    <= '0;
      n2_r    <= '0;
      n3_r    <= '0;
      miss_r  <= '0;
      idx_r   <= '0;
      pend_r  <= 1'b0;
      slot_r  <= '0;
    end else begin
      state_r <= state_nxt;
      lcg_r   <= lcg_nxt;
      fill_r  <= fill_nxt;
      n1_r    <= n1_nxt;
      n2_r    <= n2_nxt;
      n3_r    <= n3_nxt;
      miss_r  <= miss_nxt;
      idx_r   <= idx_nxt;
      pend_r  <= pend_nxt;
      slot_r  <= slot_nxt;
    end
  end

  // Payload registers, no reset.
  always_ff @(posedge clk) begin
    cand_r <= cand_nxt;
    prev_r <= prev_nxt;
  end

  always_comb begin
    state_nxt  = state_r;
    lcg_nxt    = lcg_r;
    cand_nxt   = cand_r;
    prev_nxt   = prev_r;
    fill_nxt   = fill_r;
    n1_nxt     = n1_r;
    n2_nxt     = n2_r;
    n3_nxt     = n3_r;
    miss_nxt   = miss_r;
    idx_nxt    = idx_r;
    pend_nxt   = pend_r;
    slot_nxt   = slot_r;
    wr_en      = 1'b0;
    take       = 1'b0;
    drop       = 1'b0;
    in_tready  = 1'b0;
    out_tvalid = 1'b0;

    unique case (state_r)
      hctg_pkg::ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          lcg_nxt   = ~in_tdata;
          fill_nxt  = '0;
          n1_nxt    = '0;
          n2_nxt    = '0;
          n3_nxt    = '0;
          miss_nxt  = '0;
          state_nxt = hctg_pkg::ST_STEP;
        end
      end
      hctg_pkg::ST_STEP: begin
        lcg_nxt   = prod + hctg_pkg::LCG_ADD_LO;
        state_nxt = hctg_pkg::ST_SCREEN;
      end
      hctg_pkg::ST_SCREEN: begin
        cand_nxt  = hctg_pkg::chan_of(lcg_r[15:8]);
        state_nxt = hctg_pkg::ST_CHECK;
      end
      hctg_pkg::ST_CHECK: begin
        if (spacing_bad || band_full) begin
          drop = 1'b1;
        end else if (fill_r == '0) begin
          take = 1'b1;
        end else begin
          idx_nxt   = '0;
          pend_nxt  = 1'b0;
          state_nxt = hctg_pkg::ST_SCAN;
        end
      end
      hctg_pkg::ST_SCAN: begin
        // Read at idx_r, compare the registered word in the next cycle.
        if (pend_r && (rd_r == cand_r)) begin
          drop = 1'b1;
        end else if (!issue && !pend_r) begin
          take = 1'b1;
        end else begin
          pend_nxt = issue;
          if (issue) begin
            idx_nxt = idx_r + 6'd1;
          end
        end
      end
      hctg_pkg::ST_OUT_RD: begin
        state_nxt = hctg_pkg::ST_OUT_SHOW;
      end
      hctg_pkg::ST_OUT_SHOW: begin
        out_tvalid = 1'b1;
        if (out_tready) begin
          if (slot_r == hctg_pkg::HOP_COUNT) begin
            state_nxt = hctg_pkg::ST_IDLE;
          end else begin
            slot_nxt  = slot_r + 6'd1;
            state_nxt = hctg_pkg::ST_OUT_RD;
          end
        end
      end
      default: state_nxt = hctg_pkg::ST_IDLE;
    endcase

    if (take) begin
      wr_en    = 1'b1;
      fill_nxt = fill_r + 6'd1;
      prev_nxt = cand_r;
      miss_nxt = '0;
      if (cand_r < hctg_pkg::BAND2_START)      n1_nxt = n1_r + 5'd1;
      else if (cand_r < hctg_pkg::BAND3_START) n2_nxt = n2_r + 5'd1;
      else                                     n3_nxt = n3_r + 5'd1;
      slot_nxt  = '0;
      state_nxt = (fill_r == hctg_pkg::HOP_COUNT - 6'd1) ? hctg_pkg::ST_OUT_RD
                                                          : hctg_pkg::ST_STEP;
    end
    if (drop) begin
      // A full generator period without acceptance ends the run.
      miss_nxt  = miss_r + 16'd1;
      slot_nxt  = '0;
      state_nxt = (miss_r == '1) ? hctg_pkg::ST_OUT_RD : hctg_pkg::ST_STEP;
    end
  end

  // Unfilled slots and the bind slot read as channel 0.
  assign out_tdata = {3'b000, ((slot_r < fill_r) ? rd_r : 7'd0), slot_r};
  assign out_tlast = (slot_r == hctg_pkg::HOP_COUNT);

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= hctg_pkg::HOP_COUNT)
    else $error("fill count past hop count");

  a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == hctg_pkg::ST_SCAN) |-> (idx_r <= fill_r))
    else $error("scan index past fill count");

  a_sides_apart: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_tready && out_tvalid))
    else $error("input ready while output item pending");

  a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tready && out_tlast) |=> in_tready)
    else $error("not idle after last item");

  a_write_new: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |=> (fill_r == $past(fill_r) + 6'd1))
    else $error("list write without fill advance");

endmodule

`default_nettype wire
